>>> hw/rtl/tcp_flow_stats_tracker_assert.svh
// Assertion macros for the flow statistics tracker.
// Both expect signals named clock and reset in the module that uses them.
`ifndef TCP_FLOW_STATS_TRACKER_ASSERT_SVH
`define TCP_FLOW_STATS_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define TFST_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define TFST_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define TFST_ASSERT(name, prop, msg)
`define TFST_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

>>> hw/rtl/tfst_pkg.sv
package tfst_pkg;

   // Transport protocol codes.
   localparam logic [1:0] PROTO_OTHER = 2'd0;
   localparam logic [1:0] PROTO_TCP   = 2'd1;
   localparam logic [1:0] PROTO_UDP   = 2'd2;

   // Bit positions in the TCP flag field.
   localparam int FLAG_SYN = 0;
   localparam int FLAG_ACK = 1;
   localparam int FLAG_RST = 2;

   // Highest port that the server-port test counts as well known.
   localparam logic [15:0] WELL_KNOWN_MAX = 16'd1024;

   localparam int LISTED_COUNT = 15;
   localparam logic [15:0] LISTED_PORTS [LISTED_COUNT] = '{
      16'd1194, 16'd1433, 16'd3306, 16'd3478, 16'd5222, 16'd5432, 16'd5900, 16'd6379,
      16'd6443, 16'd8080, 16'd8443, 16'd9092, 16'd9200, 16'd27017, 16'd51820
   };

   // True when a port looks like the server end of a connection.
   function automatic logic server_port(input logic [15:0] port);
      logic hit;
      hit = (port != 16'd0) && (port <= WELL_KNOWN_MAX);
      for (int i = 0; i < LISTED_COUNT; i++) begin
         if (port == LISTED_PORTS[i]) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

>>> hw/rtl/tcp_flow_stats_tracker.sv
// A result is registered once the slot update finishes; the update waits while
// the previous result is held by rsp_stall. A new packet is taken only after the
// write back of the flow table, a single memory with a registered read port.
// Reset: synchronous; afterwards a clearing pass over all FLOW_SLOTS slots marks
// every flow slot invalid, and no packet is taken until it ends.
module tcp_flow_stats_tracker
   import tfst_pkg::*;
#(
   parameter int FLOW_SLOTS = 1024,
   parameter int ADDR_BITS  = 32,
   parameter int TIME_BITS  = 48,
   parameter int COUNT_BITS = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [9:0]            req_flow_slot,
   input  logic [ADDR_BITS-1:0]  req_src_addr,
   input  logic [ADDR_BITS-1:0]  req_dst_addr,
   input  logic [15:0]           req_src_port,
   input  logic [15:0]           req_dst_port,
   input  logic [1:0]            req_proto,
   input  logic [TIME_BITS-1:0]  req_timestamp_us,
   input  logic [15:0]           req_frame_length,
   input  logic [15:0]           req_payload_length,
   input  logic [31:0]           req_tcp_seq,
   input  logic [2:0]            req_tcp_flags,
   input  logic                  req_tunnel_mark,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_accepted,
   output logic                  rsp_downstream,
   output logic [COUNT_BITS-1:0] rsp_packet_count,
   output logic [COUNT_BITS-1:0] rsp_bytes_up,
   output logic [COUNT_BITS-1:0] rsp_bytes_down,
   output logic [TIME_BITS-1:0]  rsp_first_seen_us,
   output logic [TIME_BITS-1:0]  rsp_initial_rtt_us,
   output logic [31:0]           rsp_retrans_up,
   output logic [31:0]           rsp_retrans_down,
   output logic [31:0]           rsp_reorder_up,
   output logic [31:0]           rsp_reorder_down,
   output logic                  rsp_tunnel_seen
);

`include "tcp_flow_stats_tracker_assert.svh"

   localparam int SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FLOW_SLOTS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [31:0] EVENT_MAX = '1;

   typedef struct packed {
      logic                  valid;
      logic [TIME_BITS-1:0]  first_seen;
      logic [COUNT_BITS-1:0] packets;
      logic [COUNT_BITS-1:0] bytes_up;
      logic [COUNT_BITS-1:0] bytes_down;
      logic                  tunnel;
      logic                  syn_seen;
      logic [TIME_BITS-1:0]  syn_time;
      logic [TIME_BITS-1:0]  rtt;
      logic                  up_seq_valid;
      logic [31:0]           up_next_seq;
      logic                  down_seq_valid;
      logic [31:0]           down_next_seq;
      logic [31:0]           retrans_up;
      logic [31:0]           retrans_down;
      logic [31:0]           reorder_up;
      logic [31:0]           reorder_down;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     clr_idx_ff, clr_idx_in;

   // Captured packet.
   logic [SLOT_W-1:0]     slot_ff;
   logic [ADDR_BITS-1:0]  src_addr_ff, dst_addr_ff;
   logic [15:0]           src_port_ff, dst_port_ff;
   logic [1:0]            proto_ff;
   logic [TIME_BITS-1:0]  ts_ff;
   logic [15:0]           flen_ff, plen_ff;
   logic [31:0]           seq_ff;
   logic [2:0]            flags_ff;
   logic                  tunnel_ff;

   // Flow table.
   entry_type             flow_mem [FLOW_SLOTS];
   entry_type             rd_data_ff;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_waddr;
   entry_type             mem_wdata;

   logic                  req_xfer;
   logic [SLOT_W-1:0]     req_slot;
   logic                  out_free;
   logic                  finish;
   logic                  known_proto;
   logic                  down;
   entry_type             upd;

   logic                  rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign req_slot  = SLOT_W'(32'(req_flow_slot) % FLOW_SLOTS);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_UPDATE) && out_free;
   assign known_proto = (proto_ff == PROTO_TCP) || (proto_ff == PROTO_UDP);

   // Sequencer: clearing pass, wait for a packet, update the slot.
   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   // Packet capture at the input transfer.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         slot_ff     <= req_slot;
         src_addr_ff <= req_src_addr;
         dst_addr_ff <= req_dst_addr;
         src_port_ff <= req_src_port;
         dst_port_ff <= req_dst_port;
         proto_ff    <= req_proto;
         ts_ff       <= req_timestamp_us;
         flen_ff     <= req_frame_length;
         plen_ff     <= req_payload_length;
         seq_ff      <= req_tcp_seq;
         flags_ff    <= req_tcp_flags;
         tunnel_ff   <= req_tunnel_mark;
      end
   end

   // Flow table with one write port and a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         flow_mem[mem_waddr] <= mem_wdata;
      end
      if (req_xfer) begin
         rd_data_ff <= flow_mem[req_slot];
      end
   end

   // Direction from the server-port test, then numeric endpoint order.
   always_comb begin
      logic src_srv, dst_srv;
      src_srv = server_port(src_port_ff) && !server_port(dst_port_ff);
      dst_srv = server_port(dst_port_ff) && !server_port(src_port_ff);
      priority if (src_srv) begin
         down = 1'b1;
      end else if (dst_srv) begin
         down = 1'b0;
      end else if ((src_addr_ff < dst_addr_ff) ||
                   ((src_addr_ff == dst_addr_ff) && (src_port_ff < dst_port_ff))) begin
         down = 1'b0;
      end else begin
         down = 1'b1;
      end
   end

   // Read-modify-write of the slot.
   always_comb begin
      logic                  tcp, syn, ack, rst;
      logic [COUNT_BITS:0]   byte_sum;
      logic [COUNT_BITS-1:0] byte_base;
      logic                  sq_valid;
      logic [31:0]           sq_next, sq_retr, sq_reord;
      logic [31:0]           seg_end, offset, ahead;

      tcp = (proto_ff == PROTO_TCP);
      syn = tcp && flags_ff[FLAG_SYN];
      ack = tcp && flags_ff[FLAG_ACK];
      rst = tcp && flags_ff[FLAG_RST];

      upd = rd_data_ff;
      // A slot seen for the first time starts from zero.
      if (!rd_data_ff.valid) begin
         upd            = '0;
         upd.valid      = 1'b1;
         upd.first_seen = ts_ff;
      end

      if (upd.packets != COUNT_MAX) begin
         upd.packets = upd.packets + 1'b1;
      end

      byte_base = down ? upd.bytes_down : upd.bytes_up;
      byte_sum  = {1'b0, byte_base} + (COUNT_BITS+1)'(flen_ff);
      if (byte_sum > {1'b0, COUNT_MAX}) begin
         byte_base = COUNT_MAX;
      end else begin
         byte_base = byte_sum[COUNT_BITS-1:0];
      end
      if (down) begin
         upd.bytes_down = byte_base;
      end else begin
         upd.bytes_up = byte_base;
      end

      if (tunnel_ff) begin
         upd.tunnel = 1'b1;
      end

      // Handshake round trip, measured once.
      if (tcp && (upd.rtt == '0)) begin
         if (syn && !ack && !down && !upd.syn_seen) begin
            upd.syn_time = ts_ff;
            upd.syn_seen = 1'b1;
         end else if (syn && ack && down && upd.syn_seen) begin
            if (ts_ff > upd.syn_time) begin
               upd.rtt = ts_ff - upd.syn_time;
            end
         end
      end

      // Sequence tracking in the packet's direction.
      sq_valid = down ? upd.down_seq_valid : upd.up_seq_valid;
      sq_next  = down ? upd.down_next_seq : upd.up_next_seq;
      sq_retr  = down ? upd.retrans_down : upd.retrans_up;
      sq_reord = down ? upd.reorder_down : upd.reorder_up;
      seg_end  = seq_ff + 32'(plen_ff);
      offset   = seq_ff - sq_next;
      ahead    = seg_end - sq_next;
      if (tcp && (plen_ff != 16'd0)) begin
         priority if (!sq_valid) begin
            sq_next  = seg_end;
            sq_valid = 1'b1;
         end else if (offset == 32'd0) begin
            sq_next = seg_end;
         end else if (offset[31]) begin
            if (sq_retr != EVENT_MAX) begin
               sq_retr = sq_retr + 1'b1;
            end
            if ((ahead != 32'd0) && !ahead[31]) begin
               sq_next = seg_end;
            end
         end else begin
            if (sq_reord != EVENT_MAX) begin
               sq_reord = sq_reord + 1'b1;
            end
            sq_next = seg_end;
         end
      end
      if (down) begin
         upd.down_seq_valid = sq_valid;
         upd.down_next_seq  = sq_next;
         upd.retrans_down   = sq_retr;
         upd.reorder_down   = sq_reord;
      end else begin
         upd.up_seq_valid = sq_valid;
         upd.up_next_seq  = sq_next;
         upd.retrans_up   = sq_retr;
         upd.reorder_up   = sq_reord;
      end

      // A reset segment drops both baselines.
      if (rst) begin
         upd.up_seq_valid   = 1'b0;
         upd.up_next_seq    = '0;
         upd.down_seq_valid = 1'b0;
         upd.down_next_seq  = '0;
      end
   end

   // Write port: clearing pass or slot update.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = upd;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = '0;
      end else if (finish && known_proto) begin
         mem_we = 1'b1;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         if (known_proto) begin
            rsp_accepted       <= 1'b1;
            rsp_downstream     <= down;
            rsp_packet_count   <= upd.packets;
            rsp_bytes_up       <= upd.bytes_up;
            rsp_bytes_down     <= upd.bytes_down;
            rsp_first_seen_us  <= upd.first_seen;
            rsp_initial_rtt_us <= upd.rtt;
            rsp_retrans_up     <= upd.retrans_up;
            rsp_retrans_down   <= upd.retrans_down;
            rsp_reorder_up     <= upd.reorder_up;
            rsp_reorder_down   <= upd.reorder_down;
            rsp_tunnel_seen    <= upd.tunnel;
         end else begin
            rsp_accepted       <= 1'b0;
            rsp_downstream     <= 1'b0;
            rsp_packet_count   <= '0;
            rsp_bytes_up       <= '0;
            rsp_bytes_down     <= '0;
            rsp_first_seen_us  <= '0;
            rsp_initial_rtt_us <= '0;
            rsp_retrans_up     <= '0;
            rsp_retrans_down   <= '0;
            rsp_reorder_up     <= '0;
            rsp_reorder_down   <= '0;
            rsp_tunnel_seen    <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // An input transfer always leads into the slot update.
   `TFST_ASSERT_NEXT(a_xfer_to_update, req_xfer, state_ff == ST_UPDATE, "transfer lost")
   // The table is written only by the clearing pass or a finished update.
   `TFST_ASSERT(a_write_source, !mem_we || (state_ff == ST_CLEAR) || finish,
                "stray table write")
   // No result can appear during the clearing pass.
   `TFST_ASSERT(a_no_result_in_clear, (state_ff != ST_CLEAR) || !rsp_valid_ff,
                "result during clearing pass")
   // An ignored packet reports an empty result.
   `TFST_ASSERT(a_ignored_empty, !rsp_valid_ff || rsp_accepted || (rsp_packet_count == '0),
                "ignored packet carries counts")
   // An accepted packet always reports a nonzero packet count.
   `TFST_ASSERT(a_count_nonzero, !rsp_valid_ff || !rsp_accepted || (rsp_packet_count != '0),
                "accepted packet has zero count")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

// Flow statistics predictor and store of expected results.
class flow_stats_board;

   typedef struct packed {
      logic        accepted;
      logic        downstream;
      logic [47:0] packet_count;
      logic [47:0] bytes_up;
      logic [47:0] bytes_down;
      logic [47:0] first_seen_us;
      logic [47:0] initial_rtt_us;
      logic [31:0] retrans_up;
      logic [31:0] retrans_down;
      logic [31:0] reorder_up;
      logic [31:0] reorder_down;
      logic        tunnel_seen;
   } flow_result_type;

   typedef struct {
      bit          used;
      bit [47:0]   first_seen;
      bit [47:0]   packets;
      bit [47:0]   up_bytes;
      bit [47:0]   down_bytes;
      bit          tunnel;
      bit          syn_seen;
      bit [47:0]   syn_time;
      bit [47:0]   rtt;
      bit          up_ok;
      bit [31:0]   up_next;
      bit          down_ok;
      bit [31:0]   down_next;
      bit [31:0]   up_retrans;
      bit [31:0]   down_retrans;
      bit [31:0]   up_reorder;
      bit [31:0]   down_reorder;
   } flow_entry_type;

   flow_entry_type  flows [1024];
   flow_result_type pending_results [$];
   int              errors;

   function new();
      flow_entry_type blank;
      blank = '{default: 0};
      foreach (flows[i]) flows[i] = blank;
      errors = 0;
   endfunction

   static function bit is_server(bit [15:0] p);
      bit hit;
      hit = (p != 0) && (p <= tfst_pkg::WELL_KNOWN_MAX);
      for (int i = 0; i < tfst_pkg::LISTED_COUNT; i++)
         if (p == tfst_pkg::LISTED_PORTS[i]) hit = 1;
      return hit;
   endfunction

   static function bit [47:0] add48(bit [47:0] a, bit [47:0] b);
      bit [48:0] s;
      s = a + b;
      return s[48] ? '1 : s[47:0];
   endfunction

   static function bit [31:0] inc32(bit [31:0] a);
      return (a == '1) ? a : a + 1;
   endfunction

   // Serial-arithmetic sequence tracking for one direction.
   static function void follow_seq(inout bit ok, inout bit [31:0] nxt,
                                   inout bit [31:0] retr, inout bit [31:0] reord,
                                   input bit [31:0] seq, input bit [31:0] len);
      bit [31:0] tail, off, ahead;
      tail = seq + len;
      if (!ok) begin
         nxt = tail;
         ok = 1;
         return;
      end
      off = seq - nxt;
      if (off == 0) begin
         nxt = tail;
      end else if (off[31]) begin
         ahead = tail - nxt;
         retr = inc32(retr);
         if (ahead != 0 && !ahead[31]) nxt = tail;
      end else begin
         reord = inc32(reord);
         nxt = tail;
      end
   endfunction

   // Note an accepted packet transfer and queue its expected result.
   function void note_packet(bit [9:0] slot, bit [31:0] sa, bit [31:0] da, bit [15:0] sp,
                             bit [15:0] dp, bit [1:0] proto, bit [47:0] ts,
                             bit [15:0] flen, bit [15:0] plen, bit [31:0] seq,
                             bit [2:0] flags, bit tmark);
      flow_result_type r;
      flow_entry_type e;
      bit tcp, syn, ack, rst, down, ss, ds;
      r = '0;
      if (proto != tfst_pkg::PROTO_TCP && proto != tfst_pkg::PROTO_UDP) begin
         pending_results.insert(pending_results.size(), r);
         return;
      end
      tcp = (proto == tfst_pkg::PROTO_TCP);
      syn = tcp && flags[tfst_pkg::FLAG_SYN];
      ack = tcp && flags[tfst_pkg::FLAG_ACK];
      rst = tcp && flags[tfst_pkg::FLAG_RST];
      ss = is_server(sp) && !is_server(dp);
      ds = is_server(dp) && !is_server(sp);
      if (ss) down = 1;
      else if (ds) down = 0;
      else down = !(sa < da || (sa == da && sp < dp));
      e = flows[slot];
      if (!e.used) begin
         e = '{default: 0};
         e.used = 1;
         e.first_seen = ts;
      end
      e.packets = add48(e.packets, 48'd1);
      if (down) e.down_bytes = add48(e.down_bytes, 48'(flen));
      else e.up_bytes = add48(e.up_bytes, 48'(flen));
      if (tmark) e.tunnel = 1;
      // Handshake round trip, measured once per flow.
      if (tcp && e.rtt == 0) begin
         if (syn && !ack && !down && !e.syn_seen) begin
            e.syn_time = ts;
            e.syn_seen = 1;
         end else if (syn && ack && down && e.syn_seen) begin
            if (ts > e.syn_time) e.rtt = ts - e.syn_time;
         end
      end
      if (tcp && plen > 0) begin
         if (down) follow_seq(e.down_ok, e.down_next, e.down_retrans, e.down_reorder,
                              seq, 32'(plen));
         else follow_seq(e.up_ok, e.up_next, e.up_retrans, e.up_reorder, seq, 32'(plen));
      end
      if (rst) begin
         e.up_ok = 0;
         e.up_next = 0;
         e.down_ok = 0;
         e.down_next = 0;
      end
      flows[slot] = e;
      r.accepted = 1;
      r.downstream = down;
      r.packet_count = e.packets;
      r.bytes_up = e.up_bytes;
      r.bytes_down = e.down_bytes;
      r.first_seen_us = e.first_seen;
      r.initial_rtt_us = e.rtt;
      r.retrans_up = e.up_retrans;
      r.retrans_down = e.down_retrans;
      r.reorder_up = e.up_reorder;
      r.reorder_down = e.down_reorder;
      r.tunnel_seen = e.tunnel;
      pending_results.insert(pending_results.size(), r);
   endfunction

   // Compare one result transfer against the oldest expectation.
   function void check_result(flow_result_type got);
      flow_result_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected result transfer");
         errors++;
         return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.accepted !== want.accepted) begin
         $error("accepted: expected %0h actual %0h", want.accepted, got.accepted); errors++;
      end
      if (got.downstream !== want.downstream) begin
         $error("downstream: expected %0h actual %0h", want.downstream, got.downstream);
         errors++;
      end
      if (got.packet_count !== want.packet_count) begin
         $error("packet_count: expected %0h actual %0h", want.packet_count,
                got.packet_count); errors++;
      end
      if (got.bytes_up !== want.bytes_up) begin
         $error("bytes_up: expected %0h actual %0h", want.bytes_up, got.bytes_up); errors++;
      end
      if (got.bytes_down !== want.bytes_down) begin
         $error("bytes_down: expected %0h actual %0h", want.bytes_down, got.bytes_down);
         errors++;
      end
      if (got.first_seen_us !== want.first_seen_us) begin
         $error("first_seen_us: expected %0h actual %0h", want.first_seen_us,
                got.first_seen_us); errors++;
      end
      if (got.initial_rtt_us !== want.initial_rtt_us) begin
         $error("initial_rtt_us: expected %0h actual %0h", want.initial_rtt_us,
                got.initial_rtt_us); errors++;
      end
      if (got.retrans_up !== want.retrans_up) begin
         $error("retrans_up: expected %0h actual %0h", want.retrans_up, got.retrans_up);
         errors++;
      end
      if (got.retrans_down !== want.retrans_down) begin
         $error("retrans_down: expected %0h actual %0h", want.retrans_down,
                got.retrans_down); errors++;
      end
      if (got.reorder_up !== want.reorder_up) begin
         $error("reorder_up: expected %0h actual %0h", want.reorder_up, got.reorder_up);
         errors++;
      end
      if (got.reorder_down !== want.reorder_down) begin
         $error("reorder_down: expected %0h actual %0h", want.reorder_down,
                got.reorder_down); errors++;
      end
      if (got.tunnel_seen !== want.tunnel_seen) begin
         $error("tunnel_seen: expected %0h actual %0h", want.tunnel_seen, got.tunnel_seen);
         errors++;
      end
   endfunction

endclass

module tb;
   import tfst_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [9:0]  req_flow_slot = 0;
   logic [31:0] req_src_addr = 0;
   logic [31:0] req_dst_addr = 0;
   logic [15:0] req_src_port = 0;
   logic [15:0] req_dst_port = 0;
   logic [1:0]  req_proto = PROTO_OTHER;
   logic [47:0] req_timestamp_us = 0;
   logic [15:0] req_frame_length = 0;
   logic [15:0] req_payload_length = 0;
   logic [31:0] req_tcp_seq = 0;
   logic [2:0]  req_tcp_flags = 0;
   logic        req_tunnel_mark = 0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   logic        rsp_accepted;
   logic        rsp_downstream;
   logic [47:0] rsp_packet_count;
   logic [47:0] rsp_bytes_up;
   logic [47:0] rsp_bytes_down;
   logic [47:0] rsp_first_seen_us;
   logic [47:0] rsp_initial_rtt_us;
   logic [31:0] rsp_retrans_up;
   logic [31:0] rsp_retrans_down;
   logic [31:0] rsp_reorder_up;
   logic [31:0] rsp_reorder_down;
   logic        rsp_tunnel_seen;

   flow_stats_board board = new();
   int          cycle_count = 0;
   bit          hold_off = 0;
   bit          stimulus_done = 0;
   logic [47:0] clock_us = 48'd100;
   // Per-slot next sequence for well-formed segments, per direction.
   logic [31:0] up_seq [16];
   logic [31:0] down_seq [16];

   tcp_flow_stats_tracker uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Sample transfers on both channels.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_packet(req_flow_slot, req_src_addr, req_dst_addr, req_src_port,
                           req_dst_port, req_proto, req_timestamp_us, req_frame_length,
                           req_payload_length, req_tcp_seq, req_tcp_flags,
                           req_tunnel_mark);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_accepted, rsp_downstream, rsp_packet_count, rsp_bytes_up,
                             rsp_bytes_down, rsp_first_seen_us, rsp_initial_rtt_us,
                             rsp_retrans_up, rsp_retrans_down, rsp_reorder_up,
                             rsp_reorder_down, rsp_tunnel_seen});
   end

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver stall pattern, with one long hold-off on request.
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         n = gap_length();
         if (n > 0 && !stimulus_done) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         n = $urandom_range(1, 12);
         repeat (n) @(posedge clock);
      end
   end

   // Offer one packet and wait for its transfer.
   task automatic send_packet(logic [9:0] slot, logic [31:0] sa, logic [31:0] da,
                              logic [15:0] sp, logic [15:0] dp, logic [1:0] proto,
                              logic [47:0] ts, logic [15:0] flen, logic [15:0] plen,
                              logic [31:0] seq, logic [2:0] flags, logic tmark,
                              bit idle_after);
      int n;
      req_valid <= 1;
      req_flow_slot <= slot;
      req_src_addr <= sa;
      req_dst_addr <= da;
      req_src_port <= sp;
      req_dst_port <= dp;
      req_proto <= proto;
      req_timestamp_us <= ts;
      req_frame_length <= flen;
      req_payload_length <= plen;
      req_tcp_seq <= seq;
      req_tcp_flags <= flags;
      req_tunnel_mark <= tmark;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = idle_after ? gap_length() : 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Random packet: mostly well-formed flows on a few slots, some noise.
   task automatic random_packet(bit idle_after);
      logic [9:0]  slot;
      logic [31:0] ca, sa;
      logic [15:0] cp, sp, plen;
      logic [31:0] seq;
      logic [2:0]  flags;
      logic [1:0]  proto;
      bit          down;
      int          roll, fs;
      roll = $urandom_range(0, 99);
      clock_us = clock_us + 48'($urandom_range(0, 50));
      if (roll < 15) begin
         send_packet(10'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom),
                     2'($urandom), 48'({$urandom, $urandom}), 16'($urandom),
                     16'($urandom), $urandom, 3'($urandom), 1'($urandom), idle_after);
         return;
      end
      fs = $urandom_range(0, 15);
      slot = 10'(fs * 61);
      ca = 32'h0A00_0000 + fs;
      sa = 32'hC0A8_0001 + fs;
      cp = 16'(40000 + fs);
      sp = (fs < 8) ? LISTED_PORTS[fs] : 16'(fs * 40 + 1);
      down = $urandom_range(0, 1);
      proto = ($urandom_range(0, 9) == 0) ? PROTO_UDP : PROTO_TCP;
      plen = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 1460));
      seq = down ? down_seq[fs] : up_seq[fs];
      // Perturb the sequence now and then to cause retransmissions and reordering.
      case ($urandom_range(0, 9))
         0: seq = seq - $urandom_range(1, 3000);
         1: seq = seq + $urandom_range(1, 3000);
         2: seq = $urandom;
         default: ;
      endcase
      flags = 3'($urandom_range(0, 9) == 0 ? $urandom : (1 << FLAG_ACK));
      if (roll < 20) flags = down ? 3'b011 : 3'b001;
      if (down) down_seq[fs] = seq + plen;
      else up_seq[fs] = seq + plen;
      if (down) send_packet(slot, sa, ca, sp, cp, proto, clock_us, 16'($urandom), plen, seq,
                            flags, $urandom_range(0, 19) == 0, idle_after);
      else send_packet(slot, ca, sa, cp, sp, proto, clock_us, 16'($urandom), plen, seq,
                       flags, $urandom_range(0, 19) == 0, idle_after);
   endtask

   initial begin
      foreach (up_seq[i]) begin
         up_seq[i] = $urandom;
         down_seq[i] = $urandom;
      end
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: ignored protocols, extremes, handshake, sequence cases, RST.
      send_packet(10'd0, '1, '0, '1, '1, PROTO_OTHER, '1, '1, '1, '1, 3'b111, 1, 0);
      send_packet(10'd1, '0, '1, 16'd0, 16'd0, 2'd3, '0, '0, '0, '0, 3'b000, 0, 0);
      send_packet(10'd1023, '1, '1, '1, '1, PROTO_UDP, '1, '1, '1, '1, 3'b111, 1, 0);
      send_packet(10'd1023, '1, '1, '1, '1, PROTO_UDP, '1, '1, '0, '0, 3'b000, 0, 0);
      send_packet(10'd2, 32'd5, 32'd5, 16'd80, 16'd80, PROTO_UDP, 48'd7, 16'd60,
                  0, 0, 0, 0, 0);
      send_packet(10'd3, 32'd9, 32'd4, 16'd5000, 16'd6000, PROTO_TCP, 48'd1, 16'd1,
                  0, 0, 0, 0, 0);
      send_packet(10'd3, 32'd4, 32'd9, 16'd6000, 16'd5000, PROTO_TCP, 48'd2, 16'd1,
                  0, 0, 0, 0, 0);
      send_packet(10'd4, 32'd1, 32'd2, 16'd50000, 16'd443, PROTO_TCP, 48'd1000, 16'd64,
                  0, 32'hFFFF_FFF0, 3'b001, 0, 0);
      send_packet(10'd4, 32'd2, 32'd1, 16'd443, 16'd50000, PROTO_TCP, 48'd1000, 16'd64,
                  0, 0, 3'b011, 0, 0);
      send_packet(10'd4, 32'd2, 32'd1, 16'd443, 16'd50000, PROTO_TCP, 48'd1250, 16'd64,
                  0, 0, 3'b011, 0, 0);
      send_packet(10'd4, 32'd1, 32'd2, 16'd50000, 16'd443, PROTO_TCP, 48'd1300, 16'd1500,
                  16'd32, 32'hFFFF_FFF0, 3'b010, 1, 0);
      send_packet(10'd4, 32'd1, 32'd2, 16'd50000, 16'd443, PROTO_TCP, 48'd1301, 16'd1500,
                  16'd32, 32'h0000_0010, 3'b010, 0, 0);
      send_packet(10'd4, 32'd1, 32'd2, 16'd50000, 16'd443, PROTO_TCP, 48'd1302, 16'd100,
                  16'd8, 32'h0000_0000, 3'b010, 0, 0);
      send_packet(10'd4, 32'd1, 32'd2, 16'd50000, 16'd443, PROTO_TCP, 48'd1303, 16'd100,
                  16'd64, 32'h0000_0000, 3'b010, 0, 0);
      send_packet(10'd4, 32'd1, 32'd2, 16'd50000, 16'd443, PROTO_TCP, 48'd1304, 16'd100,
                  16'd8, 32'h8000_0040, 3'b010, 0, 0);
      send_packet(10'd4, 32'd1, 32'd2, 16'd50000, 16'd443, PROTO_TCP, 48'd1305, 16'd100,
                  16'd16, 32'h9000_0000, 3'b010, 0, 0);
      send_packet(10'd4, 32'd2, 32'd1, 16'd443, 16'd50000, PROTO_TCP, 48'd1306, 16'd40,
                  16'd0, 0, 3'b100, 0, 0);
      send_packet(10'd4, 32'd1, 32'd2, 16'd50000, 16'd443, PROTO_TCP, 48'd1307, 16'd100,
                  16'd8, 32'h1234, 3'b010, 0, 0);
      send_packet(10'd5, 32'd7, 32'd8, 16'd51820, 16'd9200, PROTO_TCP, 48'd5, 16'd0,
                  16'hFFFF, 32'hFFFF_FFFF, 3'b110, 0, 0);

      // Long receiver hold-off while packets keep coming.
      hold_off = 1;
      repeat (40) random_packet(0);

      // Random part.
      repeat (1880) random_packet(1);
      req_valid <= 0;
      stimulus_done = 1;

      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
